// ===== design/physical_frame_allocator_assert.svh =====
// Assertion macros for the physical frame allocator.
// Used by physical_frame_allocator.sv; expects signals named clock and reset in scope.
`ifndef PHYSICAL_FRAME_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pfa_pkg.sv =====
// Package for the physical frame allocator: sizes, codes, payload and state types.
// No dependencies; used by pfa_ctrl and physical_frame_allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   localparam int MAX_FRAMES     = 4096;
   localparam int COUNT_BITS     = 8;
   localparam int FRAME_SHIFT    = 12;
   localparam int WORD_BITS      = 32;
   localparam int TOTAL_BITS     = 13;
   localparam int TOTAL_RESET    = 4096;
   localparam int ADDR_BITS      = 32;

   localparam int FRAME_IDX_BITS = $clog2(MAX_FRAMES);
   localparam int LIMIT_BITS     = FRAME_IDX_BITS + 1;
   localparam int WORDS          = MAX_FRAMES / WORD_BITS;
   localparam int WORD_IDX_BITS  = $clog2(WORDS);
   localparam int BIT_IDX_BITS   = $clog2(WORD_BITS);
   localparam int LIMIT_RESET    = (TOTAL_RESET < MAX_FRAMES) ? TOTAL_RESET : MAX_FRAMES;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic CMD_FIND = 1'b0;
   localparam logic CMD_MARK = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [ADDR_BITS-1:0] phys_address;
   } pfa_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] frame_address;
      logic                 found;
      logic                 out_of_range;
      logic [31:0]          used_frames;
   } pfa_rsp_type;

   typedef struct packed {
      logic                      cnt_we;
      logic [FRAME_IDX_BITS-1:0] cnt_addr;
      logic [COUNT_BITS-1:0]     cnt_wdata;
      logic                      map_we;
      logic [WORD_IDX_BITS-1:0]  map_waddr;
      logic [WORD_IDX_BITS-1:0]  map_raddr;
      logic [WORD_BITS-1:0]      map_wdata;
   } pfa_mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_MARK_RD,
      ST_MARK_WR
   } pfa_state_type;

endpackage

`default_nettype wire

// ===== design/pfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/pfa_ctrl.sv =====
// Sequencer of the physical frame allocator: bitmap scan, count update and result register.
// Depends on pfa_pkg; drives the count RAM and the in-use bitmap RAM held in the top level.
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire pfa_pkg::pfa_req_type              req_data,
   input  wire logic [pfa_pkg::LIMIT_BITS-1:0]    lim,
   output pfa_pkg::pfa_mem_req_type               mem_req,
   input  wire logic [pfa_pkg::COUNT_BITS-1:0]    cnt_rdata,
   input  wire logic [pfa_pkg::WORD_BITS-1:0]     map_rdata,
   output logic                                   rsp_valid,
   output pfa_pkg::pfa_rsp_type                   rsp_data
);

   pfa_pkg::pfa_state_type                   state_ff, state_in;
   logic [pfa_pkg::WORD_IDX_BITS-1:0]        scan_w_ff, scan_w_in;
   logic [pfa_pkg::FRAME_IDX_BITS-1:0]       idx_ff, idx_in;
   logic [pfa_pkg::WORDS-1:0]                valid_ff, valid_in;
   logic [31:0]                              used_ff, used_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   pfa_pkg::pfa_rsp_type                     rsp_ff, rsp_in;

   logic [pfa_pkg::ADDR_BITS-1:0]            req_idx;
   logic                                     req_oor;
   logic [pfa_pkg::WORD_IDX_BITS-1:0]        word_sel;
   logic [pfa_pkg::WORD_BITS-1:0]            word_eff;
   logic [pfa_pkg::LIMIT_BITS-1:0]           rem;
   logic [pfa_pkg::WORD_BITS-1:0]            range_mask;
   logic [pfa_pkg::WORD_BITS-1:0]            free_bits;
   logic                                     hit;
   logic [pfa_pkg::BIT_IDX_BITS-1:0]         hit_bit;
   logic [pfa_pkg::BIT_IDX_BITS-1:0]         mark_bit;
   logic [pfa_pkg::COUNT_BITS-1:0]           cnt_eff;

   assign req_idx = req_data.phys_address >> pfa_pkg::FRAME_SHIFT;
   assign req_oor = req_idx >= pfa_pkg::ADDR_BITS'(lim);

   assign mark_bit = idx_ff[pfa_pkg::BIT_IDX_BITS-1:0];
   assign word_sel = (state_ff == pfa_pkg::ST_MARK_RD || state_ff == pfa_pkg::ST_MARK_WR)
                     ? idx_ff[pfa_pkg::FRAME_IDX_BITS-1:pfa_pkg::BIT_IDX_BITS] : scan_w_ff;

   // A bitmap word never written reads as all free.
   assign word_eff = valid_ff[word_sel] ? map_rdata : '0;
   assign cnt_eff  = word_eff[mark_bit] ? cnt_rdata : '0;

   assign rem = lim - pfa_pkg::LIMIT_BITS'({scan_w_ff, {pfa_pkg::BIT_IDX_BITS{1'b0}}});

   always_comb begin
      if (rem >= pfa_pkg::LIMIT_BITS'(pfa_pkg::WORD_BITS)) begin
         range_mask = '1;
      end else begin
         range_mask = ~({pfa_pkg::WORD_BITS{1'b1}} << rem[pfa_pkg::BIT_IDX_BITS-1:0]);
      end
      free_bits = ~word_eff & range_mask;
      hit       = |free_bits;
      hit_bit   = '0;
      for (int b = pfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit_bit = pfa_pkg::BIT_IDX_BITS'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_w_ff <= scan_w_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      scan_w_in    = scan_w_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      mem_req           = '0;
      mem_req.cnt_addr  = idx_ff;
      mem_req.map_waddr = word_sel;
      mem_req.map_raddr = word_sel;

      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.command == pfa_pkg::CMD_MARK) begin
                  if (req_oor) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in              = '0;
                     rsp_in.out_of_range = 1'b1;
                     rsp_in.used_frames  = used_ff;
                  end else begin
                     idx_in   = req_idx[pfa_pkg::FRAME_IDX_BITS-1:0];
                     state_in = pfa_pkg::ST_MARK_RD;
                  end
               end else begin
                  scan_w_in = '0;
                  state_in  = pfa_pkg::ST_FIND_RD;
               end
            end
         end
         pfa_pkg::ST_FIND_RD: begin
            state_in = pfa_pkg::ST_FIND_CHK;
         end
         pfa_pkg::ST_FIND_CHK: begin
            if (hit) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.found         = 1'b1;
               rsp_in.frame_address = pfa_pkg::ADDR_BITS'({scan_w_ff, hit_bit})
                                      << pfa_pkg::FRAME_SHIFT;
               rsp_in.used_frames   = used_ff;
               state_in             = pfa_pkg::ST_IDLE;
            end else if (rem > pfa_pkg::LIMIT_BITS'(pfa_pkg::WORD_BITS)) begin
               scan_w_in = scan_w_ff + 1'b1;
               state_in  = pfa_pkg::ST_FIND_RD;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.used_frames = used_ff;
               state_in           = pfa_pkg::ST_IDLE;
            end
         end
         pfa_pkg::ST_MARK_RD: begin
            state_in = pfa_pkg::ST_MARK_WR;
         end
         pfa_pkg::ST_MARK_WR: begin
            mem_req.cnt_we    = 1'b1;
            mem_req.cnt_wdata = (cnt_eff == pfa_pkg::COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
            mem_req.map_we    = 1'b1;
            mem_req.map_wdata = word_eff | (pfa_pkg::WORD_BITS'(1) << mark_bit);
            valid_in[word_sel] = 1'b1;
            used_in            = used_ff + 32'd1;
            rsp_valid_in       = 1'b1;
            rsp_in             = '0;
            rsp_in.used_frames = used_ff + 32'd1;
            state_in           = pfa_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != pfa_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/physical_frame_allocator.sv =====
// Top level of the physical frame allocator: frame limit register, ledger RAMs, sequencer.
// Depends on pfa_pkg, pfa_ram, pfa_ctrl and physical_frame_allocator_assert.svh.
//
// A request is taken at a rising edge with start high and busy low. A find request
// scans an in-use bitmap, 32 frames per word, and returns the byte address of the
// lowest frame under the frame limit with a zero use count, with found set, or with
// found clear if there is none. A mark request turns the address into a frame index,
// bumps that frame's saturating count and the wrapping used-frame counter; an index at
// or beyond the frame limit sets out_of_range and changes nothing. Each request yields
// one result, shown for one cycle with rsp_valid; the receiver has no way to stall it.
// A find reads 1 to 128 bitmap words, each in a RAM read state and a check state; a
// mark reads the count and bitmap word, then writes both back; an out-of-range mark
// answers from idle. The next request is taken in the cycle the result is shown.
// Reset clears the bitmap valid flags, so the whole ledger reads as free at once,
// with no clearing pass; the used-frame counter goes to zero and the limit to 4096.
// csr_we writes total_frames, capped at the ledger size; the user must write it only
// while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module physical_frame_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire pfa_pkg::pfa_req_type             req_data,
   output logic                                  rsp_valid,
   output pfa_pkg::pfa_rsp_type                  rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [pfa_pkg::TOTAL_BITS-1:0]   csr_wdata
);

   logic [pfa_pkg::LIMIT_BITS-1:0]     lim_ff, lim_in;
   pfa_pkg::pfa_mem_req_type           mem_req;
   logic [pfa_pkg::COUNT_BITS-1:0]     cnt_rdata;
   logic [pfa_pkg::WORD_BITS-1:0]      map_rdata;

   always_comb begin
      lim_in = lim_ff;
      if (csr_we) begin
         if (32'(csr_wdata) > 32'(pfa_pkg::MAX_FRAMES)) begin
            lim_in = pfa_pkg::LIMIT_BITS'(pfa_pkg::MAX_FRAMES);
         end else begin
            lim_in = pfa_pkg::LIMIT_BITS'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= pfa_pkg::LIMIT_BITS'(pfa_pkg::LIMIT_RESET);
      end else begin
         lim_ff <= lim_in;
      end
   end

   pfa_ram #(
      .WIDTH (pfa_pkg::COUNT_BITS),
      .DEPTH (pfa_pkg::MAX_FRAMES)
   ) u_count_ram (
      .clock (clock),
      .we    (mem_req.cnt_we),
      .waddr (mem_req.cnt_addr),
      .wdata (mem_req.cnt_wdata),
      .raddr (mem_req.cnt_addr),
      .rdata (cnt_rdata)
   );

   pfa_ram #(
      .WIDTH (pfa_pkg::WORD_BITS),
      .DEPTH (pfa_pkg::WORDS)
   ) u_map_ram (
      .clock (clock),
      .we    (mem_req.map_we),
      .waddr (mem_req.map_waddr),
      .wdata (mem_req.map_wdata),
      .raddr (mem_req.map_raddr),
      .rdata (map_rdata)
   );

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .lim       (lim_ff),
      .mem_req   (mem_req),
      .cnt_rdata (cnt_rdata),
      .map_rdata (map_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`include "physical_frame_allocator_assert.svh"

   `PFA_ASSERT_NEXT(a_find_goes_busy, start && !busy && req_data.command == pfa_pkg::CMD_FIND, busy, "find request did not start a scan")
   `PFA_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "result shown while still busy")
   `PFA_ASSERT_NOW(a_flags_exclusive, rsp_valid, !(rsp_data.found && rsp_data.out_of_range), "found and out_of_range both set")
   `PFA_ASSERT_NOW(a_found_in_range, rsp_valid && rsp_data.found, (rsp_data.frame_address >> pfa_pkg::FRAME_SHIFT) < 32'(lim_ff), "found frame beyond the frame limit")

endmodule

`default_nettype wire
